/* src/hpg_pkg.sv */
// Package for the homography pixel-to-gradient block: widths, register indexes,
// reset values and the payload and pipeline stage types. No dependencies.
package hpg_pkg;

  // Field and coefficient sizes.
  localparam int unsigned COORD_BITS     = 11;
  localparam int unsigned COEF_FRAC_BITS = 32;
  localparam int unsigned COEF_W         = 48;
  localparam int unsigned NUM_COEFS      = 8;
  localparam int unsigned COEF_IDX_W     = $clog2(NUM_COEFS);
  localparam int unsigned LEVEL_W        = 8;

  // Datapath widths: signed product, signed three-term sum, scaled numerator.
  localparam int unsigned PROD_W  = COEF_W + COORD_BITS + 1;
  localparam int unsigned SUM_W   = PROD_W + 2;
  localparam int unsigned NUM_W   = SUM_W + LEVEL_W;
  localparam int unsigned DIV_STEPS = LEVEL_W;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

  // 1.0 in the coefficient format.
  localparam logic [COEF_W-1:0] COEF_ONE =
    {{(COEF_W-COEF_FRAC_BITS-1){1'b0}}, 1'b1, {COEF_FRAC_BITS{1'b0}}};

  // Register indexes on the configuration port.
  localparam logic [COEF_IDX_W-1:0] COEF_A = COEF_IDX_W'(0);
  localparam logic [COEF_IDX_W-1:0] COEF_B = COEF_IDX_W'(1);
  localparam logic [COEF_IDX_W-1:0] COEF_C = COEF_IDX_W'(2);
  localparam logic [COEF_IDX_W-1:0] COEF_D = COEF_IDX_W'(3);
  localparam logic [COEF_IDX_W-1:0] COEF_E = COEF_IDX_W'(4);
  localparam logic [COEF_IDX_W-1:0] COEF_F = COEF_IDX_W'(5);
  localparam logic [COEF_IDX_W-1:0] COEF_G = COEF_IDX_W'(6);
  localparam logic [COEF_IDX_W-1:0] COEF_H = COEF_IDX_W'(7);

  // Input item.
  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
  } pix_in_t;

  // Result item.
  typedef struct packed {
    logic [LEVEL_W-1:0] u_level;
    logic [LEVEL_W-1:0] v_level;
    logic               degenerate;
  } lvl_out_t;

  // Products stage.
  typedef struct packed {
    logic [PROD_W-1:0] ax;
    logic [PROD_W-1:0] by;
    logic [PROD_W-1:0] dx;
    logic [PROD_W-1:0] ey;
    logic [PROD_W-1:0] gx;
    logic [PROD_W-1:0] hy;
  } prod_t;

  // Sums stage.
  typedef struct packed {
    logic [SUM_W-1:0] nu;
    logic [SUM_W-1:0] nv;
    logic [SUM_W-1:0] dd;
  } sums_t;

  // One quotient lane of the divider.
  typedef struct packed {
    logic [NUM_W-1:0]   rem;
    logic [LEVEL_W-1:0] quo;
    logic               zero;
    logic               sat;
  } lane_t;

  // Divider stage: shared denominator magnitude and two lanes.
  typedef struct packed {
    logic [SUM_W-1:0] den;
    lane_t            u;
    lane_t            v;
    logic             degen;
  } div_t;

endpackage

/* src/homography_pixel_to_gradient.sv */
// Top level of the homography pixel-to-gradient block: projective map of one
// pixel coordinate to two 8-bit levels. Depends on hpg_pkg.
//
//   channel   direction  valid        stall         payload
//   input     in         in_valid_i   in_stall_o    in_data_i  (pix_in_t)
//   result    out        out_valid_o  out_stall_i   out_data_o (lvl_out_t)
//   config    in         cfg_we_i     -             cfg_idx_i, cfg_data_i
//
// One item enters per cycle unless a held result stalls the pipeline; each result
// passes through products, sums, sign and scale, eight divider stages, rounding.
// The eight-stage restoring divider, one quotient bit per stage, sets the depth.
// Reset clears all valid bits and loads the identity matrix into the registers.
// A stalled result freezes the whole pipeline, so nothing is lost or repeated.
module homography_pixel_to_gradient
  import hpg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  pix_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output lvl_out_t              out_data_o,
  input  logic                  cfg_we_i,
  input  logic [COEF_IDX_W-1:0] cfg_idx_i,
  input  logic [COEF_W-1:0]     cfg_data_i
);

  // Coefficient registers.
  logic [COEF_W-1:0] coef_q [NUM_COEFS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COEFS; i++) begin
        coef_q[i] <= ((i == int'(COEF_A)) || (i == int'(COEF_E))) ? COEF_ONE : '0;
      end
    end else if (cfg_we_i) begin
      coef_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // Global advance: everything moves unless a finished result is held.
  logic adv;
  logic out_valid_q;
  lvl_out_t out_q;

  assign adv         = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !adv;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Stage 1: six coefficient-by-coordinate products.
  logic  s1_vld_q;
  prod_t s1_d, s1_q;
  logic signed [COORD_BITS:0] xs, ys;

  always_comb begin
    xs = $signed({1'b0, in_data_i.pixel_x});
    ys = $signed({1'b0, in_data_i.pixel_y});
    s1_d.ax = PROD_W'($signed(coef_q[COEF_A]) * xs);
    s1_d.by = PROD_W'($signed(coef_q[COEF_B]) * ys);
    s1_d.dx = PROD_W'($signed(coef_q[COEF_D]) * xs);
    s1_d.ey = PROD_W'($signed(coef_q[COEF_E]) * ys);
    s1_d.gx = PROD_W'($signed(coef_q[COEF_G]) * xs);
    s1_d.hy = PROD_W'($signed(coef_q[COEF_H]) * ys);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      s1_q <= s1_d;
    end
  end

  // Stage 2: numerators and denominator, exact.
  function automatic logic [SUM_W-1:0] sx_prod(input logic [PROD_W-1:0] p);
    return {{(SUM_W-PROD_W){p[PROD_W-1]}}, p};
  endfunction

  function automatic logic [SUM_W-1:0] sx_coef(input logic [COEF_W-1:0] c);
    return {{(SUM_W-COEF_W){c[COEF_W-1]}}, c};
  endfunction

  logic  s2_vld_q;
  sums_t s2_d, s2_q;

  always_comb begin
    s2_d.nu = sx_prod(s1_q.ax) + sx_prod(s1_q.by) + sx_coef(coef_q[COEF_C]);
    s2_d.nv = sx_prod(s1_q.dx) + sx_prod(s1_q.ey) + sx_coef(coef_q[COEF_F]);
    s2_d.dd = sx_prod(s1_q.gx) + sx_prod(s1_q.hy) + sx_coef(COEF_ONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_vld_q) begin
      s2_q <= s2_d;
    end
  end

  // Stage 3: magnitudes, 255 times the numerator, zero and saturation flags.
  function automatic logic [SUM_W-1:0] magn(input logic [SUM_W-1:0] n);
    return n[SUM_W-1] ? (~n + SUM_W'(1)) : n;
  endfunction

  function automatic lane_t lane_init(input logic [SUM_W-1:0] n,
                                      input logic [SUM_W-1:0] d,
                                      input logic [SUM_W-1:0] dmag);
    lane_t            l;
    logic [SUM_W-1:0] nmag;
    logic [NUM_W-1:0] num;
    nmag   = magn(n);
    num    = {nmag, {LEVEL_W{1'b0}}} - NUM_W'(nmag);
    l.rem  = num;
    l.quo  = '0;
    l.zero = (n == '0) || (n[SUM_W-1] != d[SUM_W-1]);
    l.sat  = num >= {dmag, {LEVEL_W{1'b0}}};
    return l;
  endfunction

  logic vld_q [DIV_STEPS+1];
  div_t div_q [DIV_STEPS+1];
  div_t s3_d;

  always_comb begin
    s3_d.den   = magn(s2_q.dd);
    s3_d.u     = lane_init(s2_q.nu, s2_q.dd, s3_d.den);
    s3_d.v     = lane_init(s2_q.nv, s2_q.dd, s3_d.den);
    s3_d.degen = (s2_q.dd == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_vld_q) begin
      div_q[0] <= s3_d;
    end
  end

  // Divider stages: one restoring step per stage, most significant bit first.
  function automatic lane_t div_step(input lane_t l,
                                     input logic [NUM_W-1:0] den_sh,
                                     input logic [LEVEL_W-1:0] qbit);
    lane_t r;
    r = l;
    if (l.rem >= den_sh) begin
      r.rem = l.rem - den_sh;
      r.quo = l.quo | qbit;
    end
    return r;
  endfunction

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    localparam int unsigned Sh = DIV_STEPS - 1 - k;
    div_t             st_d;
    logic [NUM_W-1:0] den_sh;

    always_comb begin
      den_sh     = NUM_W'(div_q[k].den) << Sh;
      st_d       = div_q[k];
      st_d.u     = div_step(div_q[k].u, den_sh, LEVEL_W'(1) << Sh);
      st_d.v     = div_step(div_q[k].v, den_sh, LEVEL_W'(1) << Sh);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (adv) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv && vld_q[k]) begin
        div_q[k+1] <= st_d;
      end
    end
  end

  // Final stage: round half to even, saturate, force zero where required.
  function automatic logic [LEVEL_W-1:0] lane_level(input lane_t l,
                                                    input logic [SUM_W-1:0] den,
                                                    input logic degen);
    logic [NUM_W:0]   twice;
    logic [NUM_W:0]   dext;
    logic [LEVEL_W:0] qr;
    twice = {l.rem, 1'b0};
    dext  = (NUM_W+1)'(den);
    qr    = {1'b0, l.quo};
    if ((twice > dext) || ((twice == dext) && l.quo[0])) begin
      qr = qr + (LEVEL_W+1)'(1);
    end
    if (degen || l.zero) begin
      return '0;
    end else if (l.sat || qr[LEVEL_W]) begin
      return LEVEL_MAX;
    end else begin
      return qr[LEVEL_W-1:0];
    end
  endfunction

  lvl_out_t out_d;

  always_comb begin
    out_d.u_level    = lane_level(div_q[DIV_STEPS].u, div_q[DIV_STEPS].den,
                                  div_q[DIV_STEPS].degen);
    out_d.v_level    = lane_level(div_q[DIV_STEPS].v, div_q[DIV_STEPS].den,
                                  div_q[DIV_STEPS].degen);
    out_d.degenerate = div_q[DIV_STEPS].degen;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vld_q[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && vld_q[DIV_STEPS]) begin
      out_q <= out_d;
    end
  end

`ifndef SYNTHESIS
  // An input transfer always shows up in the product stage next cycle.
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> s1_vld_q)
    else $error("accepted item did not enter the product stage");

  // A zero numerator never looks saturated unless the denominator is zero.
  a_zero_sat_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] && !div_q[0].degen && (div_q[0].u.rem == '0) |-> !div_q[0].u.sat)
    else $error("u lane with zero numerator flagged saturated");

  // After the last divider step the remainder is below the denominator unless degenerate or saturated.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[DIV_STEPS] && !div_q[DIV_STEPS].degen
      && !div_q[DIV_STEPS].u.sat && !div_q[DIV_STEPS].v.sat |->
      (div_q[DIV_STEPS].u.rem < NUM_W'(div_q[DIV_STEPS].den))
      && (div_q[DIV_STEPS].v.rem < NUM_W'(div_q[DIV_STEPS].den)))
    else $error("divider remainder not reduced below denominator");

  // A degenerate result carries zero levels.
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |->
      (out_data_o.u_level == '0) && (out_data_o.v_level == '0))
    else $error("degenerate result with nonzero level");
`endif

endmodule
